// ===== hw/rtl/grpm_pkg.sv =====
// ----------------------------------------------------------------------------
// grpm_pkg
// Shared constants, codes and types of the greedy radius point matcher.
// ----------------------------------------------------------------------------
package grpm_pkg;

  // Table size default and the ring of scan cells
  localparam int unsigned MAX_KEYPOINTS_DEF = 1024;
  localparam int unsigned CELL_COUNT        = 4;
  localparam int unsigned CELL_BITS         = $clog2(CELL_COUNT);

  // Operation codes carried in in_tuser
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_DIST_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_ERROR_LIMIT = 2'd1;

  // Register reset values: 1.0 pixel^2 (Q.8) and 9.0 (Q.4)
  localparam logic [15:0] DIST_LIMIT_RST  = 16'd256;
  localparam logic [15:0] ERROR_LIMIT_RST = 16'd144;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 48;

  // Input item payload, lowest field last
  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] point_index;
    logic [15:0] track_error;
    logic        tracked;
    logic [15:0] y_pos;
    logic [15:0] x_pos;
  } in_data_t;

  // Result item payload, lowest field last
  typedef struct packed {
    logic [5:0]  pad;
    logic [15:0] dist_sq;
    logic [9:0]  dst_index;
    logic [15:0] src_index;
  } out_data_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_SCAN
  } ctrl_state_t;

  // Keypoint write from the controller to the cells
  typedef struct packed {
    logic        we;
    logic [15:0] x;
    logic [15:0] y;
  } load_t;

  // Scan status reported by a cell, or by the whole ring
  typedef struct packed {
    logic        done;
    logic        hit;
    logic [15:0] dsq;
  } cell_stat_t;

endpackage

// ===== hw/rtl/greedy_radius_point_matcher.sv =====
// ----------------------------------------------------------------------------
// greedy_radius_point_matcher: keypoint table with greedy radius matching.
// Clear, load, unused and rejected query items complete as they are accepted.
// A query scans the table one entry per cycle around a ring of cells once no
// older match waits in the result register; no new item is taken until the
// scan ends on a match or after the last entry.
// Reset (rst_n low, synchronous) empties the table and restores the limits.
// ----------------------------------------------------------------------------
module greedy_radius_point_matcher #(
  parameter int unsigned MAX_KEYPOINTS = grpm_pkg::MAX_KEYPOINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [1:0]                       in_tuser,  // op
  // x_pos[15:0], y_pos[31:16], tracked[32], track_error[48:33],
  // point_index[64:49], zero[71:65]
  input  logic [grpm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // match items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // src_index[15:0], dst_index[25:16], dist_sq[41:26], zero[47:42]
  output logic [grpm_pkg::OUT_TDATA_W-1:0] out_tdata,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [15:0]                      cfg_data
);
  import grpm_pkg::*;

  localparam int unsigned KW = $clog2(MAX_KEYPOINTS);
  localparam int unsigned CW = $clog2(MAX_KEYPOINTS + 1);

  logic [15:0]     dist_limit_r;
  logic [15:0]     error_limit_r;
  cell_stat_t      scan;
  logic [KW-1:0]   scan_idx;
  logic            start;
  logic            flush;
  logic [15:0]     qry_x;
  logic [15:0]     qry_y;
  logic [CW-1:0]   key_count;
  load_t           load;
  logic [KW-1:0]   load_idx;

  logic [CELL_COUNT-1:0] tok_vld_in;
  logic [KW-1:0]         tok_idx_in  [CELL_COUNT];
  logic [CELL_COUNT-1:0] tok_vld_out;
  logic [KW-1:0]         tok_idx_out [CELL_COUNT];
  cell_stat_t            cell_stat   [CELL_COUNT];
  logic [KW-1:0]         cell_idx    [CELL_COUNT];
  logic [CELL_COUNT-1:0] done_vec;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_limit_r  <= DIST_LIMIT_RST;
      error_limit_r <= ERROR_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DIST_LIMIT:  dist_limit_r  <= cfg_data;
        CFG_ERROR_LIMIT: error_limit_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  grpm_ctrl #(
    .MAX_KEYPOINTS(MAX_KEYPOINTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .error_limit(error_limit_r),
    .scan       (scan),
    .scan_idx   (scan_idx),
    .start      (start),
    .flush      (flush),
    .qry_x      (qry_x),
    .qry_y      (qry_y),
    .key_count  (key_count),
    .load       (load),
    .load_idx   (load_idx),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Ring of cells; entry 0 enters at cell 0 when a scan starts
  for (genvar c = 0; c < CELL_COUNT; c++) begin : g_cell
    if (c == 0) begin : g_head
      assign tok_vld_in[c] = start | tok_vld_out[CELL_COUNT-1];
      assign tok_idx_in[c] = start ? '0 : tok_idx_out[CELL_COUNT-1];
    end else begin : g_link
      assign tok_vld_in[c] = tok_vld_out[c-1];
      assign tok_idx_in[c] = tok_idx_out[c-1];
    end

    grpm_cell #(
      .MAX_KEYPOINTS(MAX_KEYPOINTS),
      .CELL_ID      (c)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_vld_in (tok_vld_in[c]),
      .tok_idx_in (tok_idx_in[c]),
      .tok_vld_out(tok_vld_out[c]),
      .tok_idx_out(tok_idx_out[c]),
      .flush      (flush),
      .key_count  (key_count),
      .qry_x      (qry_x),
      .qry_y      (qry_y),
      .dist_limit (dist_limit_r),
      .load       (load),
      .load_idx   (load_idx),
      .stat       (cell_stat[c]),
      .stat_idx   (cell_idx[c])
    );

    assign done_vec[c] = cell_stat[c].done;
  end

  // Merge cell status; only one cell finishes an entry per cycle
  always_comb begin
    scan     = '0;
    scan_idx = '0;
    for (int c = 0; c < CELL_COUNT; c++) begin
      scan.done = scan.done | cell_stat[c].done;
      scan.hit  = scan.hit  | cell_stat[c].hit;
      scan.dsq  = scan.dsq  | (cell_stat[c].hit ? cell_stat[c].dsq : 16'd0);
      scan_idx  = scan_idx  | (cell_stat[c].hit ? cell_idx[c] : KW'(0));
    end
  end

`ifndef ASSERT_OFF
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld_out))
    else $error("more than one scan token in the ring");

  a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(done_vec))
    else $error("more than one cell finished an entry");

  a_ring_empty: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (tok_vld_out == '0))
    else $error("scan started with a token still in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    key_count <= CW'(MAX_KEYPOINTS))
    else $error("keypoint count beyond table size");

  a_out_from_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(scan.hit))
    else $error("match item without a hit");
`endif

endmodule

// ===== hw/rtl/grpm_cell.sv =====
// ----------------------------------------------------------------------------
// grpm_cell
// One scan cell: holds every CELL_COUNT-th keypoint with its used mark,
// tests the entry named by the arriving token against the query point and
// hands the token for the next entry to its neighbor.
// ----------------------------------------------------------------------------
module grpm_cell #(
  parameter int unsigned MAX_KEYPOINTS = grpm_pkg::MAX_KEYPOINTS_DEF,
  parameter int unsigned CELL_ID       = 0,
  localparam int unsigned KW           = $clog2(MAX_KEYPOINTS),
  localparam int unsigned CW           = $clog2(MAX_KEYPOINTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tok_vld_in,
  input  logic [KW-1:0]        tok_idx_in,
  output logic                 tok_vld_out,
  output logic [KW-1:0]        tok_idx_out,
  input  logic                 flush,
  input  logic [CW-1:0]        key_count,
  input  logic [15:0]          qry_x,
  input  logic [15:0]          qry_y,
  input  logic [15:0]          dist_limit,
  input  grpm_pkg::load_t      load,
  input  logic [KW-1:0]        load_idx,
  output grpm_pkg::cell_stat_t stat,
  output logic [KW-1:0]        stat_idx
);
  import grpm_pkg::*;

  localparam int unsigned BANK_DEPTH = (MAX_KEYPOINTS + CELL_COUNT - 1) / CELL_COUNT;
  localparam int unsigned AW         = $clog2(BANK_DEPTH);

  // Keypoint bank and used marks
  logic [15:0] key_x_mem [BANK_DEPTH];
  logic [15:0] key_y_mem [BANK_DEPTH];
  logic        used_mem  [BANK_DEPTH];

  logic          load_sel;
  logic [AW-1:0] load_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] s2_addr;
  logic [CW-1:0] idx_succ;
  logic          fwd;

  logic          tok_vld_r;
  logic [KW-1:0] tok_idx_r;
  logic          s1_vld_r;
  logic [KW-1:0] s1_idx_r;
  logic          s1_last_r;
  logic [15:0]   rd_x_r;
  logic [15:0]   rd_y_r;
  logic          rd_u_r;
  logic          s2_vld_r;
  logic [KW-1:0] s2_idx_r;
  logic          s2_last_r;
  logic          s2_used_r;
  logic [15:0]   sqx_r;
  logic [15:0]   sqy_r;

  logic [15:0]   dx;
  logic [15:0]   dy;
  logic [31:0]   prod_x;
  logic [31:0]   prod_y;
  logic [15:0]   sqx_nxt;
  logic [15:0]   sqy_nxt;
  logic [16:0]   dist_sum;
  logic [15:0]   dist_sat;
  logic          hit;

  // Decode load target and scan addresses
  assign load_sel  = load.we && (load_idx[CELL_BITS-1:0] == CELL_BITS'(CELL_ID));
  assign load_addr = load_idx[CELL_BITS +: AW];
  assign rd_addr   = tok_idx_in[CELL_BITS +: AW];
  assign s2_addr   = s2_idx_r[CELL_BITS +: AW];

  // Pass the token on while entries remain below the fill count
  assign idx_succ = CW'(tok_idx_in) + CW'(1);
  assign fwd      = idx_succ < key_count;

  // Bank writes and registered reads
  always_ff @(posedge clk) begin
    if (load_sel) begin
      key_x_mem[load_addr] <= load.x;
      key_y_mem[load_addr] <= load.y;
    end
    if (load_sel) begin
      used_mem[load_addr] <= 1'b0;
    end else if (hit) begin
      used_mem[s2_addr] <= 1'b1;
    end
    if (tok_vld_in) begin
      rd_x_r <= key_x_mem[rd_addr];
      rd_y_r <= key_y_mem[rd_addr];
      rd_u_r <= used_mem[rd_addr];
    end
  end

  // Saturated squares of the coordinate differences
  always_comb begin
    dx      = (qry_x > rd_x_r) ? (qry_x - rd_x_r) : (rd_x_r - qry_x);
    dy      = (qry_y > rd_y_r) ? (qry_y - rd_y_r) : (rd_y_r - qry_y);
    prod_x  = 32'(dx) * 32'(dx);
    prod_y  = 32'(dy) * 32'(dy);
    sqx_nxt = (|prod_x[31:16]) ? 16'hFFFF : prod_x[15:0];
    sqy_nxt = (|prod_y[31:16]) ? 16'hFFFF : prod_y[15:0];
  end

  // Pipeline valids; drop everything in flight when the scan ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
    end else if (flush) begin
      tok_vld_r <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_in && fwd;
      s1_vld_r  <= tok_vld_in;
      s2_vld_r  <= s1_vld_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    tok_idx_r <= tok_idx_in + KW'(1);
    s1_idx_r  <= tok_idx_in;
    s1_last_r <= !fwd;
    s2_idx_r  <= s1_idx_r;
    s2_last_r <= s1_last_r;
    s2_used_r <= rd_u_r;
    sqx_r     <= sqx_nxt;
    sqy_r     <= sqy_nxt;
  end

  // Sum, saturate and compare against the radius
  always_comb begin
    dist_sum = 17'(sqx_r) + 17'(sqy_r);
    dist_sat = dist_sum[16] ? 16'hFFFF : dist_sum[15:0];
    hit      = s2_vld_r && !s2_used_r && (dist_sat < dist_limit);
  end

  assign tok_vld_out = tok_vld_r;
  assign tok_idx_out = tok_idx_r;
  assign stat.done   = s2_vld_r && (hit || s2_last_r);
  assign stat.hit    = hit;
  assign stat.dsq    = dist_sat;
  assign stat_idx    = s2_idx_r;

endmodule

// ===== hw/rtl/grpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// grpm_ctrl
// Item sequencer: decodes clear, load and query items, keeps the fill count,
// starts a scan of the ring and registers the match item.
// ----------------------------------------------------------------------------
module grpm_ctrl #(
  parameter int unsigned MAX_KEYPOINTS = grpm_pkg::MAX_KEYPOINTS_DEF,
  localparam int unsigned KW           = $clog2(MAX_KEYPOINTS),
  localparam int unsigned CW           = $clog2(MAX_KEYPOINTS + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [1:0]                      in_tuser,
  input  logic [grpm_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [15:0]                     error_limit,
  input  grpm_pkg::cell_stat_t            scan,
  input  logic [KW-1:0]                   scan_idx,
  output logic                            start,
  output logic                            flush,
  output logic [15:0]                     qry_x,
  output logic [15:0]                     qry_y,
  output logic [CW-1:0]                   key_count,
  output grpm_pkg::load_t                 load,
  output logic [KW-1:0]                   load_idx,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [grpm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import grpm_pkg::*;

  ctrl_state_t   state_r;
  ctrl_state_t   state_nxt;
  logic [CW-1:0] key_count_r;
  logic [CW-1:0] key_count_nxt;
  logic [15:0]   qry_x_r;
  logic [15:0]   qry_y_r;
  logic [15:0]   qry_idx_r;
  logic          capture;
  logic          out_vld_r;
  logic          out_vld_nxt;
  out_data_t     out_data_r;
  out_data_t     out_data_nxt;
  in_data_t      in_d;

  assign in_d = in_data_t'(in_tdata);

  // Next state, table bookkeeping and scan start
  always_comb begin
    state_nxt     = state_r;
    key_count_nxt = key_count_r;
    in_tready     = 1'b0;
    start         = 1'b0;
    capture       = 1'b0;
    load.we       = 1'b0;
    load.x        = in_d.x_pos;
    load.y        = in_d.y_pos;
    load_idx      = key_count_r[KW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_tuser)
            OP_CLEAR: begin
              key_count_nxt = '0;
            end
            OP_LOAD: begin
              if (key_count_r != CW'(MAX_KEYPOINTS)) begin
                load.we       = 1'b1;
                key_count_nxt = key_count_r + CW'(1);
              end
            end
            OP_QUERY: begin
              if (in_d.tracked && (in_d.track_error < error_limit) &&
                  (key_count_r != '0)) begin
                capture   = 1'b1;
                state_nxt = ST_WAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WAIT: begin
        // start only once the result register is free
        if (!out_vld_r || out_tready) begin
          start     = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign flush = scan.done;

  // Result register
  always_comb begin
    out_data_nxt = out_data_r;
    out_vld_nxt  = out_vld_r;
    if (scan.hit) begin
      out_vld_nxt            = 1'b1;
      out_data_nxt.pad       = '0;
      out_data_nxt.src_index = qry_idx_r;
      out_data_nxt.dst_index = 10'(scan_idx);
      out_data_nxt.dist_sq   = scan.dsq;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      key_count_r <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_count_r <= key_count_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // Query point and result payload
  always_ff @(posedge clk) begin
    if (capture) begin
      qry_x_r   <= in_d.x_pos;
      qry_y_r   <= in_d.y_pos;
      qry_idx_r <= in_d.point_index;
    end
    out_data_r <= out_data_nxt;
  end

  assign qry_x      = qry_x_r;
  assign qry_y      = qry_y_r;
  assign key_count  = key_count_r;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
